@@ sv/bvm_pkg.sv @@
`default_nettype none

package bvm_pkg;

    localparam int BVM_ADC_BITS = 12;
    localparam int CURVE_POINTS = 21;
    localparam int SEG_W        = $clog2(CURVE_POINTS);
    localparam int CELL_MIN_MV  = 2500;
    localparam int CELL_MAX_MV  = 4500;
    localparam int SOC_FULL     = 1000;

    localparam int CELL_W = 3;
    localparam int GAIN_W = 24;
    localparam int CAL_W  = 15;
    localparam int PACK_W = 15;
    localparam int SOC_W  = 10;
    localparam int SPU_W  = 8;
    localparam int SUM_W  = 23;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 32;
    localparam int CFG_DW = 24;
    localparam int CFG_IW = 3;
    localparam int MV_TW  = 13;

    // divider sizing: interpolation numerator needs 25 bits, span fits 15
    localparam int DIV_NW = 25;
    localparam int DIV_DW = 15;

    typedef enum logic [CFG_IW-1:0] {
        CFG_SERIES_CELLS = 3'd0,
        CFG_GAIN         = 3'd1,
        CFG_CAL_SCALE    = 3'd2,
        CFG_WARN         = 3'd3,
        CFG_CRIT         = 3'd4,
        CFG_SPU          = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_LOW    = 2'd1,
        ST_CRIT   = 2'd2,
        ST_FAULT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_AVG_START,
        S_AVG_WAIT,
        S_SOC_CHECK,
        S_SOC_SEARCH,
        S_SOC_MUL,
        S_SOC_START,
        S_SOC_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [CELL_W-1:0] series_cells;
        logic [GAIN_W-1:0] gain_q16;
        logic [CAL_W-1:0]  cal_scale_q14;
        logic [PACK_W-1:0] warn_mv;
        logic [PACK_W-1:0] crit_mv;
        logic [SPU_W-1:0]  samples_per_update;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

    // per-cell discharge curve, highest voltage first
    function automatic logic [MV_TW-1:0] curve_mv(input logic [SEG_W-1:0] i);
        logic [MV_TW-1:0] v;
        case (i)
            5'd0:    v = 13'd4200;
            5'd1:    v = 13'd4150;
            5'd2:    v = 13'd4110;
            5'd3:    v = 13'd4080;
            5'd4:    v = 13'd4020;
            5'd5:    v = 13'd3980;
            5'd6:    v = 13'd3950;
            5'd7:    v = 13'd3910;
            5'd8:    v = 13'd3870;
            5'd9:    v = 13'd3850;
            5'd10:   v = 13'd3840;
            5'd11:   v = 13'd3820;
            5'd12:   v = 13'd3800;
            5'd13:   v = 13'd3790;
            5'd14:   v = 13'd3770;
            5'd15:   v = 13'd3750;
            5'd16:   v = 13'd3730;
            5'd17:   v = 13'd3710;
            5'd18:   v = 13'd3690;
            5'd19:   v = 13'd3610;
            5'd20:   v = 13'd3270;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

    function automatic logic [SOC_W-1:0] curve_tenths(input logic [SEG_W-1:0] i);
        logic [SOC_W-1:0] v;
        case (i)
            5'd0:    v = 10'd1000;
            5'd1:    v = 10'd950;
            5'd2:    v = 10'd900;
            5'd3:    v = 10'd850;
            5'd4:    v = 10'd800;
            5'd5:    v = 10'd750;
            5'd6:    v = 10'd700;
            5'd7:    v = 10'd650;
            5'd8:    v = 10'd600;
            5'd9:    v = 10'd550;
            5'd10:   v = 10'd500;
            5'd11:   v = 10'd450;
            5'd12:   v = 10'd400;
            5'd13:   v = 10'd350;
            5'd14:   v = 10'd300;
            5'd15:   v = 10'd250;
            5'd16:   v = 10'd200;
            5'd17:   v = 10'd150;
            5'd18:   v = 10'd100;
            5'd19:   v = 10'd50;
            5'd20:   v = 10'd0;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/bvm_if.sv @@
`default_nettype none

interface bvm_in_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [ADC_BITS-1:0] adc_sample;
    logic [31:0]         now_ms;

    modport source (output valid, output cmd, output adc_sample, output now_ms, input ready);
    modport sink   (input valid, input cmd, input adc_sample, input now_ms, output ready);
endinterface

interface bvm_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] pack_mv;
    logic [9:0]  soc_tenths;
    logic [1:0]  status;
    logic        reading_valid;
    logic        critical_latched;
    logic [31:0] latch_time_ms;
    logic [31:0] update_time_ms;

    modport source (output valid, output pack_mv, output soc_tenths, output status,
                    output reading_valid, output critical_latched, output latch_time_ms,
                    output update_time_ms, input ready);
    modport sink   (input valid, input pack_mv, input soc_tenths, input status,
                    input reading_valid, input critical_latched, input latch_time_ms,
                    input update_time_ms, output ready);
endinterface

`default_nettype wire

@@ sv/battery_voltage_monitor_unit.sv @@
// channel   dir  handshake      payload
// in_ch     in   valid/ready    cmd, adc_sample, now_ms
// out_ch    out  valid/ready    pack_mv, soc_tenths, status, reading_valid,
//                               critical_latched, latch_time_ms, update_time_ms
// cfg       in   cfg_we only    cfg_idx, cfg_data
//
// A clear command is handled in idle; a sample inside a window takes two passes
// through the shared multiplier, then the accumulate step. Closing a window goes
// straight to output with no valid sample, takes one divider run when the
// average sits at a curve end, and two runs plus a segment search otherwise.
// Reset clears all window and latch state and loads the register defaults.
// A result waiting in the output register stalls only the next window close.
`default_nettype none

module battery_voltage_monitor_unit
    import bvm_pkg::*;
#(
    parameter int ADC_BITS = BVM_ADC_BITS
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_idx,
    input  wire logic [CFG_DW-1:0] cfg_data,
    bvm_in_if.sink                 in_ch,
    bvm_out_if.source              out_ch
);

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_SERIES_CELLS: cfg_next.series_cells       = cfg_data[CELL_W-1:0];
                CFG_GAIN:         cfg_next.gain_q16           = cfg_data[GAIN_W-1:0];
                CFG_CAL_SCALE:    cfg_next.cal_scale_q14      = cfg_data[CAL_W-1:0];
                CFG_WARN:         cfg_next.warn_mv            = cfg_data[PACK_W-1:0];
                CFG_CRIT:         cfg_next.crit_mv            = cfg_data[PACK_W-1:0];
                CFG_SPU:          cfg_next.samples_per_update = cfg_data[SPU_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.series_cells       <= CELL_W'(3);
            cfg_reg.gain_q16           <= GAIN_W'(52800);
            cfg_reg.cal_scale_q14      <= CAL_W'(16384);
            cfg_reg.warn_mv            <= PACK_W'(11100);
            cfg_reg.crit_mv            <= PACK_W'(10500);
            cfg_reg.samples_per_update <= SPU_W'(8);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bvm_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

@@ sv/bvm_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle while busy; a start is ignored until the division is done
module bvm_div
    import bvm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW:0]   rem_sh;
    logic              qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        qbit      = (rem_sh >= {1'b0, den_reg});
        if (busy_reg)
        begin
            rem_next = qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[DIV_NW-2:0], qbit};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIV_NW);
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

@@ sv/bvm_ctrl.sv @@
`default_nettype none

// sequencer around one shared multiplier and the divider
module bvm_ctrl
    import bvm_pkg::*;
#(
    parameter int ADC_BITS = BVM_ADC_BITS
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    bvm_in_if.sink     in_ch,
    bvm_out_if.source  out_ch
);

    localparam int MUL_AW = ADC_BITS + 8;
    localparam int MUL_BW = GAIN_W;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int MV_W   = ADC_BITS + 9;

    state_t              state_reg, state_next;
    logic [ADC_BITS-1:0] adc_reg, adc_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                fault_reg, fault_next;
    logic [PACK_W-1:0]   pack_reg, pack_next;
    logic [SOC_W-1:0]    soc_reg, soc_next;
    logic [TIME_W-1:0]   upd_reg, upd_next;
    logic                latch_reg, latch_next;
    logic [TIME_W-1:0]   stamp_reg, stamp_next;
    logic [SEG_W-1:0]    seg_reg, seg_next;
    logic [PACK_W-1:0]   diff_reg, diff_next;
    logic [DIV_DW-1:0]   span_reg, span_next;

    logic                out_valid_reg, out_valid_next;
    logic [PACK_W-1:0]   out_pack_reg, out_pack_next;
    logic [SOC_W-1:0]    out_soc_reg, out_soc_next;
    status_t             out_status_reg, out_status_next;
    logic                out_rv_reg, out_rv_next;
    logic                out_latch_reg, out_latch_next;
    logic [TIME_W-1:0]   out_stamp_reg, out_stamp_next;
    logic [TIME_W-1:0]   out_upd_reg, out_upd_next;

    logic [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    logic [MV_W-1:0]     mv;
    logic [PACK_W-1:0]   lim_lo, lim_hi;
    logic                mv_ok;
    logic [CNT_W:0]      idx_inc;
    logic                win_end;
    logic [SUM_W-1:0]    sum_add;
    logic [CNT_W-1:0]    cnt_add;
    logic [SEG_W-1:0]    seg_nx;
    logic [15:0]         p16, hi_mv, lo_mv, top_mv, end_mv;
    logic [SOC_W-1:0]    dp;
    logic [DIV_NW:0]     soc_sum;
    status_t             st;

    bvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next      = state_reg;
        adc_next        = adc_reg;
        now_next        = now_reg;
        prod_next       = prod_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        fault_next      = fault_reg;
        pack_next       = pack_reg;
        soc_next        = soc_reg;
        upd_next        = upd_reg;
        latch_next      = latch_reg;
        stamp_next      = stamp_reg;
        seg_next        = seg_reg;
        diff_next       = diff_reg;
        span_next       = span_reg;
        out_valid_next  = out_valid_reg;
        out_pack_next   = out_pack_reg;
        out_soc_next    = out_soc_reg;
        out_status_next = out_status_reg;
        out_rv_next     = out_rv_reg;
        out_latch_next  = out_latch_reg;
        out_stamp_next  = out_stamp_reg;
        out_upd_next    = out_upd_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_req         = '0;
        in_ch.ready     = 1'b0;

        mv      = prod_reg[14 +: MV_W];
        lim_lo  = PACK_W'(cfg.series_cells) * PACK_W'(CELL_MIN_MV);
        lim_hi  = PACK_W'(cfg.series_cells) * PACK_W'(CELL_MAX_MV);
        mv_ok   = (cfg.samples_per_update != '0) && (mv != '0) &&
                  (mv >= MV_W'(lim_lo)) && (mv <= MV_W'(lim_hi));
        idx_inc = {1'b0, idx_reg} + (CNT_W+1)'(1);
        win_end = (cfg.samples_per_update == '0) ||
                  (idx_inc >= {1'b0, cfg.samples_per_update});
        sum_add = mv_ok ? (sum_reg + SUM_W'(mv)) : sum_reg;
        cnt_add = mv_ok ? (cnt_reg + CNT_W'(1)) : cnt_reg;

        seg_nx  = seg_reg + SEG_W'(1);
        p16     = 16'(pack_reg);
        hi_mv   = 16'(cfg.series_cells) * 16'(curve_mv(seg_reg));
        lo_mv   = 16'(cfg.series_cells) * 16'(curve_mv(seg_nx));
        top_mv  = 16'(cfg.series_cells) * 16'(curve_mv(SEG_W'(0)));
        end_mv  = 16'(cfg.series_cells) * 16'(curve_mv(SEG_W'(CURVE_POINTS - 1)));
        dp      = curve_tenths(seg_reg) - curve_tenths(seg_nx);
        soc_sum = (DIV_NW+1)'(curve_tenths(seg_nx)) + (DIV_NW+1)'(div_rsp.quo);

        if (pack_reg <= cfg.crit_mv)
            st = ST_CRIT;
        else if (pack_reg <= cfg.warn_mv)
            st = ST_LOW;
        else
            st = ST_NORMAL;

        // drop the held result once it transfers
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.cmd)
                    begin
                        latch_next = 1'b0;
                        stamp_next = '0;
                    end
                    else
                    begin
                        adc_next   = in_ch.adc_sample;
                        now_next   = in_ch.now_ms;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                mul_a      = MUL_AW'(adc_reg);
                mul_b      = cfg.gain_q16;
                prod_next  = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_a      = prod_reg[16 +: MUL_AW];
                mul_b      = MUL_BW'(cfg.cal_scale_q14);
                prod_next  = mul_p;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_add;
                cnt_next = cnt_add;
                if (!win_end)
                begin
                    idx_next   = idx_inc[CNT_W-1:0];
                    state_next = S_IDLE;
                end
                else if (cnt_add == '0)
                begin
                    fault_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    fault_next = 1'b0;
                    state_next = S_AVG_START;
                end
            end
            S_AVG_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(sum_reg);
                div_req.den   = DIV_DW'(cnt_reg);
                state_next    = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    pack_next  = div_rsp.quo[PACK_W-1:0];
                    state_next = S_SOC_CHECK;
                end
            end
            S_SOC_CHECK:
            begin
                seg_next = '0;
                if (cfg.series_cells == '0)
                begin
                    soc_next   = '0;
                    state_next = S_EMIT;
                end
                else if (p16 >= top_mv)
                begin
                    soc_next   = SOC_W'(SOC_FULL);
                    state_next = S_EMIT;
                end
                else if (p16 <= end_mv)
                begin
                    soc_next   = '0;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_SOC_SEARCH;
            end
            S_SOC_SEARCH:
            begin
                if ((p16 <= hi_mv) && (p16 >= lo_mv))
                begin
                    diff_next = PACK_W'(p16 - lo_mv);
                    span_next = DIV_DW'(hi_mv - lo_mv);
                    if (hi_mv == lo_mv)
                    begin
                        soc_next   = curve_tenths(seg_reg);
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_SOC_MUL;
                end
                else if (seg_reg == SEG_W'(CURVE_POINTS - 2))
                begin
                    soc_next   = '0;
                    state_next = S_EMIT;
                end
                else
                    seg_next = seg_nx;
            end
            S_SOC_MUL:
            begin
                mul_a      = MUL_AW'(dp);
                mul_b      = MUL_BW'(diff_reg);
                prod_next  = mul_p;
                state_next = S_SOC_START;
            end
            S_SOC_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = prod_reg[DIV_NW-1:0];
                div_req.den   = span_reg;
                state_next    = S_SOC_WAIT;
            end
            S_SOC_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (soc_sum > (DIV_NW+1)'(SOC_FULL))
                        soc_next = SOC_W'(SOC_FULL);
                    else
                        soc_next = soc_sum[SOC_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pack_next  = pack_reg;
                    out_soc_next   = soc_reg;
                    out_latch_next = latch_reg;
                    out_stamp_next = stamp_reg;
                    out_upd_next   = upd_reg;
                    if (fault_reg)
                    begin
                        out_status_next = ST_FAULT;
                        out_rv_next     = 1'b0;
                    end
                    else
                    begin
                        out_status_next = st;
                        out_rv_next     = 1'b1;
                        upd_next        = now_reg;
                        out_upd_next    = now_reg;
                        if (st == ST_CRIT)
                        begin
                            latch_next     = 1'b1;
                            stamp_next     = now_reg;
                            out_latch_next = 1'b1;
                            out_stamp_next = now_reg;
                        end
                    end
                    sum_next   = '0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            fault_reg     <= 1'b0;
            pack_reg      <= '0;
            soc_reg       <= '0;
            upd_reg       <= '0;
            latch_reg     <= 1'b0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            fault_reg     <= fault_next;
            pack_reg      <= pack_next;
            soc_reg       <= soc_next;
            upd_reg       <= upd_next;
            latch_reg     <= latch_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg        <= adc_next;
        now_reg        <= now_next;
        prod_reg       <= prod_next;
        seg_reg        <= seg_next;
        diff_reg       <= diff_next;
        span_reg       <= span_next;
        out_pack_reg   <= out_pack_next;
        out_soc_reg    <= out_soc_next;
        out_status_reg <= out_status_next;
        out_rv_reg     <= out_rv_next;
        out_latch_reg  <= out_latch_next;
        out_stamp_reg  <= out_stamp_next;
        out_upd_reg    <= out_upd_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.pack_mv          = out_pack_reg;
    assign out_ch.soc_tenths       = out_soc_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.reading_valid    = out_rv_reg;
    assign out_ch.critical_latched = out_latch_reg;
    assign out_ch.latch_time_ms    = out_stamp_reg;
    assign out_ch.update_time_ms   = out_upd_reg;

endmodule

`default_nettype wire
